@@ rtl/core/hcmp_pkg.sv @@
`default_nettype none
package hcmp_pkg;

   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int GUARD_BITS        = 12;
   localparam int HEADROOM_BITS     = 4;
   localparam int TABLE_LEN         = 24;
   localparam int ANGLE_BITS        = 35;
   localparam int OUT_ANGLE_BITS    = 16;
   localparam int OUT_PITCH_BITS    = 15;

   localparam logic [0:0] MODE_VECTOR = 1'b0;
   localparam logic [0:0] MODE_ROTATE = 1'b1;

   localparam logic signed [ANGLE_BITS-1:0] ANG_PI      = 35'sd3373259426;
   localparam logic signed [ANGLE_BITS-1:0] ANG_HALF_PI = 35'sd1686629713;
   localparam logic signed [ANGLE_BITS-1:0] OUT_PI      = 35'sd25736;
   localparam logic signed [ANGLE_BITS-1:0] OUT_HALF_PI = 35'sd12868;
   localparam longint INV_GAIN_Q16 = 39797;

   // atan(2^-i) in Q30, truncated
   function automatic logic signed [ANGLE_BITS-1:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0:       v = 32'h3243F6A8;
         1:       v = 32'h1DAC6705;
         2:       v = 32'h0FADBAFC;
         3:       v = 32'h07F56EA6;
         4:       v = 32'h03FEAB76;
         5:       v = 32'h01FFD55B;
         6:       v = 32'h00FFFAAA;
         7:       v = 32'h007FFF55;
         8:       v = 32'h003FFFEA;
         9:       v = 32'h001FFFFD;
         10:      v = 32'h000FFFFF;
         11:      v = 32'h0007FFFF;
         12:      v = 32'h0003FFFF;
         13:      v = 32'h0001FFFF;
         14:      v = 32'h0000FFFF;
         15:      v = 32'h00007FFF;
         16:      v = 32'h00003FFF;
         17:      v = 32'h00001FFF;
         18:      v = 32'h00000FFF;
         19:      v = 32'h000007FF;
         20:      v = 32'h000003FF;
         21:      v = 32'h000001FF;
         22:      v = 32'h000000FF;
         23:      v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return $signed({3'b000, v});
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/hcmp_cell.sv @@
`default_nettype none
module hcmp_cell
   import hcmp_pkg::*;
#(
   parameter int          DW   = 32,
   parameter int          SW   = 1,
   parameter int          IDX  = 0,
   parameter logic [0:0]  MODE = MODE_VECTOR
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          in_valid,
   input  wire  logic signed [DW-1:0]   in_x,
   input  wire  logic signed [DW-1:0]   in_y,
   input  wire  logic signed [ANGLE_BITS-1:0] in_z,
   input  wire  logic [SW-1:0]          in_side,
   output logic                         out_valid,
   output logic signed [DW-1:0]         out_x,
   output logic signed [DW-1:0]         out_y,
   output logic signed [ANGLE_BITS-1:0] out_z,
   output logic [SW-1:0]                out_side
);

   localparam logic signed [ANGLE_BITS-1:0] ATAN = atan_q30(IDX);

   logic                         valid_ff;
   logic signed [DW-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_BITS-1:0] z_ff, z_in;
   logic [SW-1:0]                side_ff;
   logic                         dir_pos;
   logic signed [DW-1:0]         xs, ys;

   always_comb begin
      xs = in_x >>> IDX;
      ys = in_y >>> IDX;
      // vectoring drives y to zero, rotation drives z to zero
      dir_pos = (MODE == MODE_VECTOR) ? !in_y[DW-1] : !in_z[ANGLE_BITS-1];
      if (MODE == MODE_VECTOR) begin
         if (dir_pos) begin
            x_in = in_x + ys;
            y_in = in_y - xs;
            z_in = in_z + ATAN;
         end else begin
            x_in = in_x - ys;
            y_in = in_y + xs;
            z_in = in_z - ATAN;
         end
      end else begin
         if (dir_pos) begin
            x_in = in_x - ys;
            y_in = in_y + xs;
            z_in = in_z - ATAN;
         end else begin
            x_in = in_x + ys;
            y_in = in_y - xs;
            z_in = in_z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

@@ rtl/core/hcmp_cordic.sv @@
`default_nettype none
module hcmp_cordic
   import hcmp_pkg::*;
#(
   parameter int          DW   = 32,
   parameter int          SW   = 1,
   parameter int          NS   = 16,
   parameter logic [0:0]  MODE = MODE_VECTOR
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          in_valid,
   input  wire  logic signed [DW-1:0]   in_x,
   input  wire  logic signed [DW-1:0]   in_y,
   input  wire  logic signed [ANGLE_BITS-1:0] in_z,
   input  wire  logic [SW-1:0]          in_side,
   output logic                         out_valid,
   output logic signed [DW-1:0]         out_x,
   output logic signed [DW-1:0]         out_y,
   output logic signed [ANGLE_BITS-1:0] out_z,
   output logic [SW-1:0]                out_side
);

   localparam int PW = DW + 18;
   localparam logic signed [PW-1:0] INV_W = PW'(INV_GAIN_Q16);
   localparam logic signed [PW-1:0] RND_W = PW'(32768);

   // pre-rotation stage
   logic                         pv_ff, pzero_ff, pzero_in;
   logic signed [DW-1:0]         px_ff, px_in, py_ff, py_in;
   logic signed [ANGLE_BITS-1:0] pz_ff, pz_in;
   logic [SW-1:0]                pside_ff;

   always_comb begin
      px_in    = in_x;
      py_in    = in_y;
      pz_in    = in_z;
      pzero_in = 1'b0;
      if (MODE == MODE_VECTOR) begin
         pzero_in = (in_x == '0) && (in_y == '0);
         if (in_x[DW-1]) begin
            px_in = -in_x;
            py_in = -in_y;
            pz_in = in_y[DW-1] ? -ANG_PI : ANG_PI;
         end
      end else begin
         if (in_z > ANG_HALF_PI) begin
            px_in = -in_y;
            py_in = in_x;
            pz_in = in_z - ANG_HALF_PI;
         end else if (in_z < -ANG_HALF_PI) begin
            px_in = in_y;
            py_in = -in_x;
            pz_in = in_z + ANG_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         pzero_ff <= pzero_in;
         pside_ff <= in_side;
      end
   end

   // micro-rotation chain; the zero flag rides with the sideband
   logic                         v_ch [0:NS];
   logic signed [DW-1:0]         x_ch [0:NS];
   logic signed [DW-1:0]         y_ch [0:NS];
   logic signed [ANGLE_BITS-1:0] z_ch [0:NS];
   logic [SW:0]                  s_ch [0:NS];

   assign v_ch[0] = pv_ff;
   assign x_ch[0] = px_ff;
   assign y_ch[0] = py_ff;
   assign z_ch[0] = pz_ff;
   assign s_ch[0] = {pzero_ff, pside_ff};

   for (genvar i = 0; i < NS; i++) begin : g_cell
      hcmp_cell #(
         .DW   (DW),
         .SW   (SW + 1),
         .IDX  (i),
         .MODE (MODE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v_ch[i]),
         .in_x      (x_ch[i]),
         .in_y      (y_ch[i]),
         .in_z      (z_ch[i]),
         .in_side   (s_ch[i]),
         .out_valid (v_ch[i+1]),
         .out_x     (x_ch[i+1]),
         .out_y     (y_ch[i+1]),
         .out_z     (z_ch[i+1]),
         .out_side  (s_ch[i+1])
      );
   end

   // gain correction stage
   logic                         gv_ff;
   logic signed [DW-1:0]         gx_ff, gx_in, gy_ff, gy_in;
   logic signed [ANGLE_BITS-1:0] gz_ff, gz_in;
   logic [SW-1:0]                gside_ff;
   logic signed [PW-1:0]         xe, ye, xp, yp;

   always_comb begin
      xe    = PW'(x_ch[NS]);
      ye    = PW'(y_ch[NS]);
      xp    = (xe * INV_W + RND_W) >>> 16;
      yp    = (ye * INV_W + RND_W) >>> 16;
      gx_in = xp[DW-1:0];
      gy_in = yp[DW-1:0];
      gz_in = s_ch[NS][SW] ? '0 : z_ch[NS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gv_ff <= 1'b0;
      end else if (en) begin
         gv_ff <= v_ch[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gx_ff    <= gx_in;
         gy_ff    <= gy_in;
         gz_ff    <= gz_in;
         gside_ff <= s_ch[NS][SW-1:0];
      end
   end

   assign out_valid = gv_ff;
   assign out_x     = gx_ff;
   assign out_y     = gy_ff;
   assign out_z     = gz_ff;
   assign out_side  = gside_ff;

endmodule
`default_nettype wire

@@ rtl/core/tilt_compensated_compass_heading_unit.sv @@
// Tilt-compensated compass heading. Each transaction on req carries one
// accelerometer and one magnetometer vector; rsp returns roll and yaw in
// signed Q3.13 radians and pitch in signed Q2.13, saturated to +/-pi (pitch
// +/-pi/2). The datapath is five CORDIC units of min(CORDIC_STAGES, TABLE_LEN)
// micro-rotation cells each, arranged in four phases (roll vectoring; pitch
// vectoring beside the roll rotation of the magnetometer; the pitch rotation;
// yaw vectoring). Each unit registers a pre-rotation stage, its cells and a
// gain multiplier stage. One transaction is accepted every cycle; the whole
// pipe holds while rsp is stalled.
`default_nettype none
module tilt_compensated_compass_heading_unit
   import hcmp_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
   input  wire  [((6*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31]
   output logic [47:0]          rsp_tdata
);

   localparam int SB = SAMPLE_BITS;
   localparam int DW = SAMPLE_BITS + GUARD_BITS + HEADROOM_BITS;
   localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int AW = ANGLE_BITS;

   logic en;
   logic rsp_valid_ff;
   logic [47:0] rsp_data_ff, rsp_data_in;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   function automatic logic signed [DW-1:0] scale(input logic [SB-1:0] s);
      return $signed({{HEADROOM_BITS{s[SB-1]}}, s, {GUARD_BITS{1'b0}}});
   endfunction

   logic [SB-1:0] ax, ay, az, mx, my, mz;
   assign ax = req_tdata[0*SB +: SB];
   assign ay = req_tdata[1*SB +: SB];
   assign az = req_tdata[2*SB +: SB];
   assign mx = req_tdata[3*SB +: SB];
   assign my = req_tdata[4*SB +: SB];
   assign mz = req_tdata[5*SB +: SB];

   // phase 1: roll = atan2(ay, az), rho = |(az, ay)|
   logic                  v1;
   logic signed [DW-1:0]  rho;
   logic signed [AW-1:0]  roll1;
   logic [4*SB-1:0]       side1;

   hcmp_cordic #(.DW(DW), .SW(4*SB), .NS(NS), .MODE(MODE_VECTOR)) u_roll (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (req_tvalid && en),
      .in_x (scale(az)), .in_y (scale(ay)), .in_z ('0),
      .in_side ({mz, my, mx, ax}),
      .out_valid (v1), .out_x (rho), .out_y (), .out_z (roll1),
      .out_side (side1)
   );

   // phase 2: pitch vectoring, magnetometer rotated by roll
   logic                  v2, v2r;
   logic signed [AW-1:0]  pitch2, roll2;
   logic signed [DW-1:0]  a2, b2;
   logic [SB-1:0]         mx2;

   hcmp_cordic #(.DW(DW), .SW(AW), .NS(NS), .MODE(MODE_VECTOR)) u_pitch (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v1),
      .in_x (rho), .in_y (-scale(side1[0 +: SB])), .in_z ('0),
      .in_side (roll1),
      .out_valid (v2), .out_x (), .out_y (), .out_z (pitch2),
      .out_side (roll2)
   );

   hcmp_cordic #(.DW(DW), .SW(SB), .NS(NS), .MODE(MODE_ROTATE)) u_rot_roll (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v1),
      .in_x (scale(side1[2*SB +: SB])), .in_y (scale(side1[3*SB +: SB])),
      .in_z (roll1),
      .in_side (side1[SB +: SB]),
      .out_valid (v2r), .out_x (a2), .out_y (b2), .out_z (),
      .out_side (mx2)
   );

   // phase 3: rotate (mx0, b) by -pitch
   logic                  v3;
   logic signed [DW-1:0]  c3;
   logic [2*AW+DW-1:0]    side3;

   hcmp_cordic #(.DW(DW), .SW(2*AW+DW), .NS(NS), .MODE(MODE_ROTATE)) u_rot_pitch (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v2 && v2r),
      .in_x (scale(mx2)), .in_y (b2), .in_z (-pitch2),
      .in_side ({a2, pitch2, roll2}),
      .out_valid (v3), .out_x (c3), .out_y (), .out_z (),
      .out_side (side3)
   );

   // phase 4: yaw = atan2(-my, mx)
   logic                  v4;
   logic signed [AW-1:0]  yaw4;
   logic [2*AW-1:0]       side4;

   hcmp_cordic #(.DW(DW), .SW(2*AW), .NS(NS), .MODE(MODE_VECTOR)) u_yaw (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v3),
      .in_x (c3), .in_y (-$signed(side3[2*AW +: DW])), .in_z ('0),
      .in_side (side3[2*AW-1:0]),
      .out_valid (v4), .out_x (), .out_y (), .out_z (yaw4),
      .out_side (side4)
   );

   function automatic logic signed [AW-1:0] round_clamp(
      input logic signed [AW-1:0] z, input logic signed [AW-1:0] lim);
      logic signed [AW-1:0] q;
      q = (z + AW'(65536)) >>> 17;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return q;
   endfunction

   logic signed [AW-1:0] roll_q, pitch_q, yaw_q;

   always_comb begin
      roll_q      = round_clamp($signed(side4[0 +: AW]), OUT_PI);
      pitch_q     = round_clamp($signed(side4[AW +: AW]), OUT_HALF_PI);
      yaw_q       = round_clamp(yaw4, OUT_PI);
      rsp_data_in = {1'b0, yaw_q[OUT_ANGLE_BITS-1:0], pitch_q[OUT_PITCH_BITS-1:0],
                     roll_q[OUT_ANGLE_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v4;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import hcmp_pkg::*;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
   } angles_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;        // roll[15:0], pitch[30:16], yaw[46:31]

   tilt_compensated_compass_heading_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   localparam int LATENCY = 4 * (CORDIC_STAGES_DEF + 2) + 1;
   localparam int CYCLE_LIMIT = 400000;

   angles_type pending_angles[$];
   int n_sent = 0;
   int n_checked = 0;
   int n_errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;

   longint atan_tab[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   localparam longint PI_Q30 = 64'd3373259426;
   localparam longint HALF_PI_Q30 = 64'd1686629713;

   function automatic longint unscale_gain(longint v);
      return (v * 39797 + (64'sd1 <<< 15)) >>> 16;
   endfunction

   // atan2(y, x) in Q30, gain-corrected magnitude out
   function automatic longint vector_angle(longint x, longint y, output longint mag);
      longint z, nx, ny;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? PI_Q30 : -PI_Q30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += atan_tab[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= atan_tab[i];
         end
         x = nx;
         y = ny;
      end
      mag = unscale_gain(x);
      return z;
   endfunction

   function automatic void rotate_by(inout longint a, inout longint b, input longint z);
      longint t, na, nb;
      if (z > HALF_PI_Q30) begin
         t = a; a = -b; b = t;
         z -= HALF_PI_Q30;
      end else if (z < -HALF_PI_Q30) begin
         t = a; a = b; b = -t;
         z += HALF_PI_Q30;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         if (z >= 0) begin
            na = a - (b >>> i);
            nb = b + (a >>> i);
            z -= atan_tab[i];
         end else begin
            na = a + (b >>> i);
            nb = b - (a >>> i);
            z += atan_tab[i];
         end
         a = na;
         b = nb;
      end
      a = unscale_gain(a);
      b = unscale_gain(b);
   endfunction

   function automatic longint to_q13(longint z, longint lim);
      longint q;
      q = (z + (64'sd1 <<< 16)) >>> 17;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return q;
   endfunction

   function automatic angles_type predict_heading(logic [95:0] d);
      longint s[6];
      longint rho, dummy, roll, pitch, yaw, a, b, c, e;
      angles_type r;
      for (int k = 0; k < 6; k++)
         s[k] = longint'($signed(d[16*k +: 16])) * 4096;
      roll = vector_angle(s[2], s[1], rho);
      pitch = vector_angle(rho, -s[0], dummy);
      a = s[4];
      b = s[5];
      rotate_by(a, b, roll);
      c = s[3];
      e = b;
      rotate_by(c, e, -pitch);
      yaw = vector_angle(c, -a, dummy);
      r.roll = 16'(to_q13(roll, 25736));
      r.pitch = 15'(to_q13(pitch, 12868));
      r.yaw = 16'(to_q13(yaw, 25736));
      return r;
   endfunction

   // scoreboard: predictions on req, compare on rsp
   always @(posedge clock) begin
      angles_type exp_a, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_angles.push_back(predict_heading(req_tdata));
            n_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.roll = rsp_tdata[15:0];
            got.pitch = rsp_tdata[30:16];
            got.yaw = rsp_tdata[46:31];
            if (pending_angles.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected transaction %h", rsp_tdata);
            end else begin
               exp_a = pending_angles.pop_front();
               n_checked++;
               if (got.roll !== exp_a.roll || got.pitch !== exp_a.pitch ||
                   got.yaw !== exp_a.yaw) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("result %0d: exp r/p/y %0d %0d %0d, got %0d %0d %0d",
                              n_checked, exp_a.roll, exp_a.pitch, exp_a.yaw,
                              got.roll, got.pitch, got.yaw);
               end
            end
         end
      end
   end

   // receiver backpressure, pattern changes every so often
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ((cycles % 7) < 2);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tilt_compensated_compass_heading_unit: mismatch");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance, or at the end of a random idle gap
   task automatic send_sample(input logic signed [15:0] ax, ay, az, mx, my, mz);
      int n0;
      int gap;
      n0 = n_sent;
      req_tvalid <= 1'b1;
      req_tdata <= {mz, my, mx, az, ay, ax};
      do @(negedge clock); while (n_sent == n0);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(0, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic test_directed();
      send_sample(0, 0, 0, 0, 0, 0);
      send_sample(-32768, -32768, -32768, -32768, -32768, -32768);
      send_sample(32767, 32767, 32767, 32767, 32767, 32767);
      send_sample(0, 0, 16384, 20000, 0, 0);          // level, north
      send_sample(0, 0, -16384, 20000, 300, 100);     // upside down
      send_sample(0, 0, -16384, 20000, -300, 100);
      send_sample(0, -100, -16384, -20000, 0, 500);   // negative x, y below zero
      send_sample(0, 16384, -100, 1000, 2000, 3000);  // roll beyond half pi
      send_sample(0, -16384, -100, 1000, 2000, 3000); // roll beyond minus half pi
      send_sample(-32768, 0, 0, 5000, 5000, 5000);    // pitch at half pi
      send_sample(32767, 0, 0, 5000, -5000, 5000);
      send_sample(100, 200, 16000, 0, 0, 0);          // zero magnetometer
      send_sample(0, 0, 16384, -20000, 1, 0);         // yaw near pi
      send_sample(0, 0, 16384, -20000, -1, 0);
      send_sample(0, 0, 16384, -20000, 0, 0);
      send_sample(1, -1, 1, -1, 1, -1);
      send_sample(-32768, 32767, -32768, 32767, -32768, 32767);
   endtask

   task automatic test_random_raw(input int count);
      for (int i = 0; i < count; i++)
         send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // random vectors with random magnitudes; about half get an accel_z near 16384
   task automatic test_random_tilted(input int count);
      logic signed [15:0] v[6];
      int sh;
      for (int i = 0; i < count; i++) begin
         sh = $urandom_range(0, 12);
         foreach (v[k]) v[k] = $signed(16'($urandom)) >>> sh;
         if ($urandom_range(0, 1)) v[2] = 16'sd16384 - (v[2] >>> 2);
         send_sample(v[0], v[1], v[2], v[3], v[4], v[5]);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_raw(700);
      test_random_tilted(730);
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
      $display("sent %0d vector pairs, checked %0d heading results over %0d cycles",
               n_sent, n_checked, cycles);
      if (n_errors == 0 && pending_angles.size() == 0)
         $display("tilt_compensated_compass_heading_unit: match");
      else
         $display("tilt_compensated_compass_heading_unit: mismatch");
      $finish;
   end
endmodule
